// ===== hw/rtl/tfd_pkg.sv =====
// ----------------------------------------------------------------------------
// tfd_pkg
// Shared types and constants of the touch flick detector: event and status
// codes, divider operations, controller command and datapath status bundles.
// ----------------------------------------------------------------------------
package tfd_pkg;

  // Field widths fixed by the interface.
  localparam int PW   = 16;
  localparam int TW   = 10;
  localparam int DENW = 10;
  localparam int VW   = 34;
  localparam int NUMW = 50;

  localparam int MS_WRAP     = 1000;
  localparam int MIN_SAMPLES = 3;
  localparam logic [TW-1:0] MIN_INTERVAL_RST = TW'(10);

  typedef enum logic [1:0] {
    CMD_DOWN = 2'd0,
    CMD_MOVE = 2'd1,
    CMD_UP   = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OPEN    = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef enum logic [2:0] {
    OP_VX  = 3'd0,
    OP_VY  = 3'd1,
    OP_AX  = 3'd2,
    OP_AY  = 3'd3,
    OP_MVX = 3'd4,
    OP_MVY = 3'd5,
    OP_MAX = 3'd6,
    OP_MAY = 3'd7
  } div_op_t;

  typedef struct packed {
    logic [PW-1:0] x;
    logic [PW-1:0] y;
    logic [TW-1:0] ms;
  } sample_t;

  typedef struct packed {
    logic    capture;
    logic    lookup;
    logic    open_slot;
    logic    rd_last;
    logic    append;
    logic    walk_init;
    logic    load_prev;
    logic    load_cur;
    logic    div_start;
    logic    div_store;
    div_op_t op;
    logic    step;
    logic    finish;
  } ctl_t;

  typedef struct packed {
    logic found;
    logic full;
    cmd_t ev;
    logic n_ge3;
    logic k_last;
    logic k_ge2;
    logic div_done;
  } stat_t;

  // Forward time distance with wrap at one second.
  function automatic logic [TW-1:0] wrap_dist(input logic [TW-1:0] cur,
                                              input logic [TW-1:0] prev);
    logic signed [TW+1:0] d;
    d = $signed({2'b00, cur}) - $signed({2'b00, prev});
    if (d < 0) d = d + (TW+2)'(MS_WRAP);
    if (d < 0) d = d + (TW+2)'(MS_WRAP);
    return d[TW-1:0];
  endfunction

  // Clamp to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [NUMW-1:0] v);
    if (v > $signed(NUMW'(64'sh7FFFFFFF))) return 32'sh7FFFFFFF;
    if (v < -$signed(NUMW'(64'sh80000000))) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic same_sign(input logic signed [31:0] v,
                                     input logic signed [31:0] a);
    return (v > 0 && a > 0) || (v < 0 && a < 0);
  endfunction

endpackage

// ===== hw/rtl/tfd_div.sv =====
// ----------------------------------------------------------------------------
// tfd_div
// Sequential signed divider, one quotient bit per cycle, rounding to nearest
// with ties away from zero.
// ----------------------------------------------------------------------------
module tfd_div
  import tfd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [NUMW-1:0] num,
  input  logic [DENW-1:0]        den,
  output logic                   done,
  output logic signed [NUMW-1:0] quo
);

  localparam int CW = $clog2(NUMW + 2);

  logic            running;
  logic [CW-1:0]   cnt;
  logic [NUMW:0]   mag;
  logic [DENW-1:0] rem;
  logic [DENW-1:0] dsr;
  logic            neg;
  logic [NUMW-1:0] absn;
  logic [DENW:0]   rem_sh;
  logic            qbit;

  // Magnitude of the numerator and one restoring step.
  always_comb begin
    absn   = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
    rem_sh = {rem, mag[NUMW]};
    qbit   = rem_sh >= {1'b0, dsr};
  end

  // Iteration over all numerator bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CW'(NUMW + 1);
        mag     <= {1'b0, absn} + (NUMW+1)'(den >> 1);
        neg     <= num[NUMW-1];
        dsr     <= den;
        rem     <= '0;
      end else if (running) begin
        rem <= qbit ? DENW'(rem_sh - {1'b0, dsr}) : rem_sh[DENW-1:0];
        mag <= {mag[NUMW-1:0], qbit};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Apply the sign to the rounded magnitude.
  assign quo = neg ? -$signed(mag[NUMW-1:0]) : $signed(mag[NUMW-1:0]);

endmodule

// ===== hw/rtl/tfd_dp.sv =====
// ----------------------------------------------------------------------------
// tfd_dp
// Datapath: slot table, sample history memory, divider, accumulators and the
// result registers.
// ----------------------------------------------------------------------------
module tfd_dp
  import tfd_pkg::*;
#(
  parameter int HISTORY_DEPTH = 8,
  parameter int MAX_TOUCHES   = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  ctl_t                ctl,
  output stat_t               st,
  input  logic [1:0]          cmd,
  input  logic [PW-1:0]       touch_id,
  input  logic [PW-1:0]       pos_x,
  input  logic [PW-1:0]       pos_y,
  input  logic [TW-1:0]       time_ms,
  input  logic                cfg_we,
  input  logic [TW-1:0]       cfg_wdata,
  output logic                done,
  output logic [1:0]          status,
  output logic                flick,
  output logic [PW-1:0]       out_touch_id,
  output logic [PW-1:0]       end_x,
  output logic [PW-1:0]       end_y,
  output logic signed [31:0]  avg_vel_x,
  output logic signed [31:0]  avg_vel_y,
  output logic signed [31:0]  avg_acc_x,
  output logic signed [31:0]  avg_acc_y
);

  localparam int HD    = HISTORY_DEPTH;
  localparam int MT    = MAX_TOUCHES;
  localparam int HDW   = $clog2(HD);
  localparam int FW    = $clog2(HD + 1);
  localparam int SLW   = (MT > 1) ? $clog2(MT) : 1;
  localparam int DEPTH = MT * HD;
  localparam int AW    = $clog2(DEPTH);

  // Slot table.
  logic              slot_valid [MT];
  logic [PW-1:0]     slot_id    [MT];
  logic [FW-1:0]     slot_fill  [MT];
  logic [HDW-1:0]    slot_old   [MT];

  // History memory.
  sample_t           mem [DEPTH];
  sample_t           rdata;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic              wr_en;
  sample_t           wr_data;

  // Latched event and lookup result.
  logic [TW-1:0]     min_int;
  cmd_t              ev;
  logic [PW-1:0]     ev_id;
  sample_t           ev_s;
  logic [SLW-1:0]    sl;
  logic              found;
  logic              full;
  logic              have_avg;

  // Walk state.
  logic [HDW-1:0]    k;
  sample_t           prv;
  sample_t           cur;
  logic [TW-1:0]     gap_ms;
  logic signed [VW-1:0]   vx, vy, pvx, pvy;
  logic signed [NUMW-1:0] svx, svy, sax, say;
  logic signed [31:0]     mvx, mvy, max_r, may_r;

  // Combinational helpers.
  logic              m_found, m_free;
  logic [SLW-1:0]    m_idx, f_idx;
  logic [FW-1:0]     fill_cur;
  logic [HDW-1:0]    old_cur;
  logic [AW-1:0]     base;
  logic [HDW:0]      off_last, off_k, off_app;
  logic [TW-1:0]     app_dist;
  logic              skip;
  logic [TW-1:0]     d_new;
  logic signed [16:0]     dxs, dys;
  logic signed [VW:0]     dvx, dvy;
  logic signed [NUMW-1:0] num;
  logic [DENW-1:0]        den;
  logic                   div_done;
  logic signed [NUMW-1:0] quo;

  // Lowest matching slot and lowest free slot.
  always_comb begin
    m_found = 1'b0;
    m_free  = 1'b0;
    m_idx   = '0;
    f_idx   = '0;
    for (int s = MT - 1; s >= 0; s--) begin
      if (slot_valid[s] && slot_id[s] == ev_id) begin
        m_found = 1'b1;
        m_idx   = SLW'(s);
      end
      if (!slot_valid[s]) begin
        m_free = 1'b1;
        f_idx  = SLW'(s);
      end
    end
  end

  // Ring addressing within the current slot.
  always_comb begin
    fill_cur = slot_fill[sl];
    old_cur  = slot_old[sl];
    base     = AW'(sl) * AW'(HD);
    off_last = {1'b0, old_cur} + (HDW+1)'(fill_cur - FW'(1));
    if (off_last >= (HDW+1)'(HD)) off_last = off_last - (HDW+1)'(HD);
    off_k = {1'b0, old_cur} + {1'b0, k};
    if (off_k >= (HDW+1)'(HD)) off_k = off_k - (HDW+1)'(HD);
    off_app = {1'b0, old_cur} + (HDW+1)'(fill_cur);
    if (off_app >= (HDW+1)'(HD)) off_app = off_app - (HDW+1)'(HD);
    if (fill_cur >= FW'(HD)) off_app = {1'b0, old_cur};
    rd_addr = base + AW'(ctl.rd_last ? off_last : off_k);
  end

  // Sample spacing checks.
  always_comb begin
    app_dist = wrap_dist(ev_s.ms, rdata.ms);
    skip     = app_dist <= min_int;
    d_new    = wrap_dist(rdata.ms, prv.ms);
    if (d_new == '0) d_new = TW'(1);
  end

  // Memory write port.
  always_comb begin
    wr_en   = ctl.open_slot || (ctl.append && !skip);
    wr_addr = ctl.open_slot ? base : base + AW'(off_app);
    wr_data = ev_s;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata <= mem[rd_addr];
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) min_int <= MIN_INTERVAL_RST;
    else if (cfg_we) min_int <= cfg_wdata;
  end

  // Event capture and lookup.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      ev    <= cmd_t'(cmd);
      ev_id <= touch_id;
      ev_s  <= '{x: pos_x, y: pos_y, ms: time_ms};
    end
    if (ctl.lookup) begin
      found <= m_found;
      full  <= !m_free;
      sl    <= m_found ? m_idx : f_idx;
    end
  end

  // Slot table updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < MT; s++) begin
        slot_valid[s] <= 1'b0;
        slot_fill[s]  <= '0;
        slot_old[s]   <= '0;
      end
    end else begin
      if (ctl.open_slot) begin
        slot_valid[sl] <= 1'b1;
        slot_id[sl]    <= ev_id;
        slot_fill[sl]  <= FW'(1);
        slot_old[sl]   <= '0;
      end
      if (ctl.append && !skip) begin
        if (fill_cur < FW'(HD)) slot_fill[sl] <= fill_cur + FW'(1);
        else if (old_cur == HDW'(HD - 1)) slot_old[sl] <= '0;
        else slot_old[sl] <= old_cur + HDW'(1);
      end
      if (ctl.finish && ev == CMD_UP && found) begin
        slot_valid[sl] <= 1'b0;
        slot_fill[sl]  <= '0;
        slot_old[sl]   <= '0;
      end
    end
  end

  // Divider operand selection.
  always_comb begin
    dxs = $signed({1'b0, cur.x}) - $signed({1'b0, prv.x});
    dys = $signed({1'b0, cur.y}) - $signed({1'b0, prv.y});
    dvx = {vx[VW-1], vx} - {pvx[VW-1], pvx};
    dvy = {vy[VW-1], vy} - {pvy[VW-1], pvy};
    den = gap_ms;
    case (ctl.op)
      OP_VX:  num = {{(NUMW-33){dxs[16]}}, dxs, 16'b0};
      OP_VY:  num = {{(NUMW-33){dys[16]}}, dys, 16'b0};
      OP_AX:  num = {{(NUMW-VW-9){dvx[VW]}}, dvx, 8'b0};
      OP_AY:  num = {{(NUMW-VW-9){dvy[VW]}}, dvy, 8'b0};
      OP_MVX: begin num = svx; den = DENW'(fill_cur - FW'(1)); end
      OP_MVY: begin num = svy; den = DENW'(fill_cur - FW'(1)); end
      OP_MAX: begin num = sax; den = DENW'(fill_cur - FW'(2)); end
      OP_MAY: begin num = say; den = DENW'(fill_cur - FW'(2)); end
      default: num = '0;
    endcase
  end

  tfd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quo   (quo)
  );

  // Walk over the history and accumulation of quotients.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      have_avg <= 1'b0;
      svx <= '0; svy <= '0; sax <= '0; say <= '0;
    end
    if (ctl.walk_init) begin
      have_avg <= 1'b1;
      k        <= '0;
    end
    if (ctl.load_prev) begin
      prv <= rdata;
      k   <= HDW'(1);
    end
    if (ctl.load_cur) begin
      cur    <= rdata;
      gap_ms <= d_new;
    end
    if (ctl.div_store) begin
      case (ctl.op)
        OP_VX:  begin vx <= quo[VW-1:0]; svx <= svx + quo; end
        OP_VY:  begin vy <= quo[VW-1:0]; svy <= svy + quo; end
        OP_AX:  sax <= sax + quo;
        OP_AY:  say <= say + quo;
        OP_MVX: mvx <= sat32(quo);
        OP_MVY: mvy <= sat32(quo);
        OP_MAX: max_r <= sat32(quo);
        OP_MAY: may_r <= sat32(quo);
        default: ;
      endcase
    end
    if (ctl.step) begin
      prv <= cur;
      pvx <= vx;
      pvy <= vy;
      k   <= k + HDW'(1);
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.finish;
    end
    if (ctl.finish) begin
      out_touch_id <= ev_id;
      end_x        <= (ev == CMD_UP && found) ? ev_s.x : '0;
      end_y        <= (ev == CMD_UP && found) ? ev_s.y : '0;
      avg_vel_x    <= have_avg ? mvx : '0;
      avg_vel_y    <= have_avg ? mvy : '0;
      avg_acc_x    <= have_avg ? max_r : '0;
      avg_acc_y    <= have_avg ? may_r : '0;
      flick        <= have_avg && (same_sign(mvx, max_r) || same_sign(mvy, may_r));
      case (ev)
        CMD_DOWN:        status <= found ? ST_OPEN : (full ? ST_FULL : ST_OK);
        CMD_MOVE, CMD_UP: status <= found ? ST_OK : ST_UNKNOWN;
        default:         status <= ST_OK;
      endcase
    end
  end

  // Status toward the controller.
  always_comb begin
    st.found    = found;
    st.full     = full;
    st.ev       = ev;
    st.n_ge3    = fill_cur >= FW'(MIN_SAMPLES);
    st.k_last   = (FW'(k) + FW'(1)) == fill_cur;
    st.k_ge2    = k >= HDW'(2);
    st.div_done = div_done;
  end

endmodule

// ===== hw/rtl/tfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// tfd_ctrl
// Controller: sequences lookup, append, history walk and the divider
// operations of one request.
// ----------------------------------------------------------------------------
module tfd_ctrl
  import tfd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  input  stat_t st,
  output ctl_t  ctl
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_LOOK   = 13'b0000000000010,
    S_DECIDE = 13'b0000000000100,
    S_APPEND = 13'b0000000001000,
    S_CHECK  = 13'b0000000010000,
    S_RD0    = 13'b0000000100000,
    S_PREV   = 13'b0000001000000,
    S_RDK    = 13'b0000010000000,
    S_CUR    = 13'b0000100000000,
    S_DGO    = 13'b0001000000000,
    S_DWAIT  = 13'b0010000000000,
    S_STEP   = 13'b0100000000000,
    S_FIN    = 13'b1000000000000
  } state_t;

  state_t  state, state_next;
  div_op_t op, op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_VX;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    op_next    = op;
    ctl        = '0;
    ctl.op     = op;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.capture = 1'b1;
          state_next  = S_LOOK;
        end
      end
      S_LOOK: begin
        ctl.lookup = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next = S_FIN;
        case (st.ev)
          CMD_DOWN: ctl.open_slot = !st.found && !st.full;
          CMD_MOVE, CMD_UP: begin
            if (st.found) begin
              ctl.rd_last = 1'b1;
              state_next  = S_APPEND;
            end
          end
          default: ;
        endcase
      end
      S_APPEND: begin
        ctl.append = 1'b1;
        state_next = (st.ev == CMD_UP) ? S_CHECK : S_FIN;
      end
      S_CHECK: begin
        if (st.n_ge3) begin
          ctl.walk_init = 1'b1;
          state_next    = S_RD0;
        end else begin
          state_next = S_FIN;
        end
      end
      S_RD0: state_next = S_PREV;
      S_PREV: begin
        ctl.load_prev = 1'b1;
        state_next    = S_RDK;
      end
      S_RDK: state_next = S_CUR;
      S_CUR: begin
        ctl.load_cur = 1'b1;
        op_next      = OP_VX;
        state_next   = S_DGO;
      end
      S_DGO: begin
        ctl.div_start = 1'b1;
        state_next    = S_DWAIT;
      end
      S_DWAIT: begin
        if (st.div_done) begin
          ctl.div_store = 1'b1;
          state_next    = S_DGO;
          case (op)
            OP_VX:  op_next = OP_VY;
            OP_VY: begin
              if (st.k_ge2) op_next = OP_AX;
              else state_next = S_STEP;
            end
            OP_AX:  op_next = OP_AY;
            OP_AY:  state_next = S_STEP;
            OP_MVX: op_next = OP_MVY;
            OP_MVY: op_next = OP_MAX;
            OP_MAX: op_next = OP_MAY;
            OP_MAY: state_next = S_FIN;
            default: state_next = S_FIN;
          endcase
        end
      end
      S_STEP: begin
        ctl.step = 1'b1;
        if (st.k_last) begin
          op_next    = OP_MVX;
          state_next = S_DGO;
        end else begin
          state_next = S_RDK;
        end
      end
      S_FIN: begin
        ctl.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/touch_flick_detector_unit.sv =====
// Down, move and unknown-id requests finish without the divider; an up whose
// slot holds n >= 3 samples after the append runs (4n - 2) divides in the
// bit-serial divider.
// One request is in flight at a time; busy is high until its result shows.
// Synchronous active-high reset frees all slots and sets min_interval_ms to 10.
// The result is shown for one cycle on done; the receiver cannot stall.
// ----------------------------------------------------------------------------
// touch_flick_detector_unit
// Top level: tracks touch histories per id and judges releases as flicks.
// ----------------------------------------------------------------------------
module touch_flick_detector_unit
  import tfd_pkg::*;
#(
  parameter int HISTORY_DEPTH = 8,
  parameter int MAX_TOUCHES   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd,
  input  logic [15:0]        touch_id,
  input  logic [15:0]        pos_x,
  input  logic [15:0]        pos_y,
  input  logic [9:0]         time_ms,
  input  logic               cfg_we,
  input  logic [9:0]         cfg_wdata,
  output logic               done,
  output logic [1:0]         status,
  output logic               flick,
  output logic [15:0]        out_touch_id,
  output logic [15:0]        end_x,
  output logic [15:0]        end_y,
  output logic signed [31:0] avg_vel_x,
  output logic signed [31:0] avg_vel_y,
  output logic signed [31:0] avg_acc_x,
  output logic signed [31:0] avg_acc_y
);

  ctl_t  ctl;
  stat_t st;

  // Sequencer.
  tfd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .st    (st),
    .ctl   (ctl)
  );

  // Storage and arithmetic.
  tfd_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .MAX_TOUCHES   (MAX_TOUCHES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .st           (st),
    .cmd          (cmd),
    .touch_id     (touch_id),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .time_ms      (time_ms),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .done         (done),
    .status       (status),
    .flick        (flick),
    .out_touch_id (out_touch_id),
    .end_x        (end_x),
    .end_y        (end_y),
    .avg_vel_x    (avg_vel_x),
    .avg_vel_y    (avg_vel_y),
    .avg_acc_x    (avg_acc_x),
    .avg_acc_y    (avg_acc_y)
  );

endmodule

// ===== hw/rtl/tfd_checker.sv =====
// ----------------------------------------------------------------------------
// tfd_checker
// Port-level checks of the request and result timing of the detector, and of error results.
// ----------------------------------------------------------------------------
module tfd_checker
  import tfd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic        flick,
  input logic [15:0] end_x
);

  // A result only appears once the block has gone idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result shown while busy");

  // An accepted request makes the block busy.
  a_take: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request accepted but not busy");

  // Each request yields one strobe, never two in a row.
  a_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe repeated");

  // A failed request never reports a flick or an end position.
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> !flick && end_x == '0)
    else $error("flick or end position on an error result");

endmodule

bind touch_flick_detector_unit tfd_checker u_tfd_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .status (status),
  .flick  (flick),
  .end_x  (end_x)
);
